// File: rtl/uer_pkg.sv
`timescale 1ns / 1ps

package uer_pkg;

	localparam int OVERFLOW_BITS_DEF = 14;
	localparam int HISTORY_DEPTH_DEF = 3;

	localparam int CAPT_W = 16;
	localparam int UM_W   = 10;
	localparam int DIST_W = 40;

	localparam logic [UM_W-1:0]   UM_RESET     = 10'd170;
	localparam logic [CAPT_W-1:0] CAPT_WRAPPED = 16'hffff;

	typedef enum logic [1:0] {
		KIND_TIMER = 2'd0,
		KIND_TRIG  = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	// control and payload that ride along with the mean computation
	typedef struct packed {
		logic              fire;
		logic              ready;
		logic              warm;
		logic [DIST_W-1:0] raw;
	} side_t;

	typedef struct packed {
		logic              fire;
		logic              ready;
		logic [DIST_W-1:0] raw;
		logic [DIST_W-1:0] filt;
	} res_t;

endpackage

// File: rtl/uer_div.sv
`timescale 1ns / 1ps

module uer_div import uer_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        adv,
	input  logic                                        in_v,
	input  logic [DIST_W+$clog2(HISTORY_DEPTH)-1:0]     in_sum,
	input  side_t                                       in_side,
	output logic                                        out_v,
	output logic [DIST_W-1:0]                           out_quot,
	output side_t                                       out_side
);

	localparam int SUMW = DIST_W + $clog2(HISTORY_DEPTH);
	localparam int RB   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int XW   = RB + 4;
	localparam int NCH  = (SUMW + 3) / 4;
	localparam int NDS  = (NCH + 1) / 2;
	localparam int PADW = NDS * 8;

	logic [3:0]    qtab [2**XW];
	logic [RB-1:0] rtab [2**XW];

	for (genvar gx = 0; gx < 2**XW; gx++) begin : g_tab
		assign qtab[gx] = 4'(gx / HISTORY_DEPTH);
		assign rtab[gx] = RB'(gx % HISTORY_DEPTH);
	end

	logic            v_q    [NDS];
	logic [PADW-1:0] quot_q [NDS];
	side_t           side_q [NDS];
	logic [PADW-1:0] num_q  [NDS-1];
	logic [RB-1:0]   rem_q  [NDS-1];

	// two remainder-chained nibbles of the long division per stage, MSB first
	for (genvar j = 0; j < NDS; j++) begin : g_stg
		localparam int C1 = 2 * NDS - 1 - 2 * j;
		localparam int C2 = C1 - 1;

		logic            vi;
		logic [PADW-1:0] ni;
		logic [PADW-1:0] qi;
		logic [RB-1:0]   ri;
		side_t           si;
		logic [XW-1:0]   x1;
		logic [XW-1:0]   x2;
		logic [RB-1:0]   r1;
		logic [RB-1:0]   r2;
		logic [3:0]      q1;
		logic [3:0]      q2;
		logic [PADW-1:0] qo;

		if (j == 0) begin : g_first
			assign vi = in_v;
			assign ni = PADW'(in_sum);
			assign qi = '0;
			assign ri = '0;
			assign si = in_side;
		end else begin : g_next
			assign vi = v_q[j-1];
			assign ni = num_q[j-1];
			assign qi = quot_q[j-1];
			assign ri = rem_q[j-1];
			assign si = side_q[j-1];
		end

		assign x1 = {ri, ni[C1*4 +: 4]};
		assign q1 = qtab[x1];
		assign r1 = rtab[x1];
		assign x2 = {r1, ni[C2*4 +: 4]};
		assign q2 = qtab[x2];
		assign r2 = rtab[x2];

		always_comb begin
			qo = qi;
			qo[C1*4 +: 4] = q1;
			qo[C2*4 +: 4] = q2;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j] <= 1'b0;
			end else if (adv) begin
				v_q[j] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quot_q[j] <= qo;
				side_q[j] <= si;
			end
		end

		if (j < NDS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					num_q[j] <= ni;
					rem_q[j] <= r2;
				end
			end
		end
	end

	assign out_v    = v_q[NDS-1];
	assign out_quot = quot_q[NDS-1][DIST_W-1:0];
	assign out_side = side_q[NDS-1];

endmodule

// File: rtl/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps

// Ultrasonic echo pulse ranger. Takes timer events, trigger requests and
// distance reads, one item per clock while in_stall is low, and returns one
// result item for each. Measurement state is updated in the cycle an item
// is taken. Two stages follow: the distance (ticks times um_per_tick, a
// 30x10 multiplier at the default overflow width) and then the mean of the
// HISTORY_DEPTH readings before it (the raw reading itself while the history
// fills), by a constant divider that retires eight quotient bits per stage.
// The divider has NDS stages, ceil(ceil(SUMW/4)/2), with SUMW being 40 plus
// ceil(log2(HISTORY_DEPTH)). Sustained rate is one item per cycle while
// results are taken. The pipeline keeps moving while a result waits, and a
// two-entry output buffer takes the next result. The input stalls while
// both entries are full. um_per_tick must be written only while no item is
// in flight; the block itself does not enforce this.

module ultrasonic_echo_ranger import uer_pkg::*; #(
	parameter int OVERFLOW_BITS = OVERFLOW_BITS_DEF,
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [UM_W-1:0]   cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic              overflow_event,
	input  logic              capture_event,
	input  logic [CAPT_W-1:0] capture_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              trigger_fire,
	output logic              reading_ready,
	output logic [DIST_W-1:0] raw_distance_um,
	output logic [DIST_W-1:0] filtered_distance_um
);

	localparam int TW   = OVERFLOW_BITS + CAPT_W;
	localparam int PRW  = TW + UM_W;
	localparam int PTRW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int WUW  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUMW = DIST_W + $clog2(HISTORY_DEPTH);

	localparam logic [PTRW-1:0]          PTR_LAST = PTRW'(HISTORY_DEPTH - 1);
	localparam logic [WUW-1:0]           WU_FULL  = WUW'(HISTORY_DEPTH);
	localparam logic [OVERFLOW_BITS-1:0] OVF_MAX  = '1;

	logic [UM_W-1:0]          um_q;
	logic                     fin_q;
	logic                     echo_q;
	logic [OVERFLOW_BITS-1:0] ovf_cnt_q;
	logic [CAPT_W-1:0]        lat_q;
	logic                     armed_q;
	logic [WUW-1:0]           wu_q;
	logic [PTRW-1:0]          ptr_q;
	logic [DIST_W-1:0]        hist_q [HISTORY_DEPTH];
	logic [SUMW-1:0]          sum_q;

	logic                     fin_n;
	logic                     echo_n;
	logic [OVERFLOW_BITS-1:0] ovf_cnt_n;
	logic [CAPT_W-1:0]        lat_n;
	logic                     armed_n;
	logic [WUW-1:0]           wu_n;
	logic [PTRW-1:0]          ptr_n;
	logic                     fire_c;
	logic                     ok_c;
	logic                     warm_c;
	logic [TW-1:0]            ticks_c;

	logic                     adv;
	logic                     accept;

	logic                     v_s1;
	logic                     fire_s1;
	logic                     ok_s1;
	logic                     warm_s1;
	logic [PTRW-1:0]          ptr_s1;
	logic [TW-1:0]            ticks_s1;
	logic [PRW-1:0]           prod_s1;

	logic                     v_s2;
	logic                     fire_s2;
	logic                     ok_s2;
	logic                     warm_s2;
	logic [PTRW-1:0]          ptr_s2;
	logic [DIST_W-1:0]        raw_s2;

	side_t                    div_side_in;
	logic                     div_v;
	logic [DIST_W-1:0]        div_quot;
	side_t                    div_side;
	res_t                     res_c;

	logic                     out_v_q;
	res_t                     out_q;
	logic                     skid_v_q;
	res_t                     skid_q;
	logic                     out_take;

	assign adv      = !skid_v_q;
	assign in_stall = skid_v_q;
	assign accept   = in_valid && adv;

	assign ticks_c = {ovf_cnt_q, {CAPT_W{1'b0}}} - TW'(ovf_cnt_q) + TW'(lat_q);

	always_comb begin
		fin_n     = fin_q;
		echo_n    = echo_q;
		ovf_cnt_n = ovf_cnt_q;
		lat_n     = lat_q;
		armed_n   = armed_q;
		wu_n      = wu_q;
		ptr_n     = ptr_q;
		fire_c    = 1'b0;
		ok_c      = 1'b0;
		warm_c    = 1'b0;
		unique case (kind)
			KIND_TIMER: begin
				if (!fin_q) begin
					if (overflow_event && echo_q) begin
						if (ovf_cnt_q == OVF_MAX) begin
							fin_n = 1'b1;
							lat_n = CAPT_WRAPPED;
						end else begin
							ovf_cnt_n = ovf_cnt_q + 1'b1;
						end
					end
					if (capture_event) begin
						if (echo_q) begin
							fin_n = 1'b1;
							lat_n = capture_value;
						end else begin
							ovf_cnt_n = '0;
							lat_n     = '0;
							fin_n     = 1'b0;
							echo_n    = 1'b1;
						end
					end
				end
			end
			KIND_TRIG: begin
				if (!armed_q && !echo_q && !fin_q) begin
					armed_n = 1'b1;
					fire_c  = 1'b1;
				end
			end
			KIND_READ: begin
				if (fin_q) begin
					fin_n     = 1'b0;
					echo_n    = 1'b0;
					ovf_cnt_n = '0;
					armed_n   = 1'b0;
					ok_c      = (ovf_cnt_q != '0 || lat_q != '0) && um_q != '0;
					if (ok_c) begin
						warm_c = wu_q != WU_FULL;
						if (warm_c) begin
							wu_n = wu_q + 1'b1;
						end
						ptr_n = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			um_q <= UM_RESET;
		end else if (cfg_we) begin
			um_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q     <= 1'b0;
			echo_q    <= 1'b0;
			ovf_cnt_q <= '0;
			lat_q     <= '0;
			armed_q   <= 1'b0;
			wu_q      <= '0;
			ptr_q     <= '0;
		end else if (accept) begin
			fin_q     <= fin_n;
			echo_q    <= echo_n;
			ovf_cnt_q <= ovf_cnt_n;
			lat_q     <= lat_n;
			armed_q   <= armed_n;
			wu_q      <= wu_n;
			ptr_q     <= ptr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	assign prod_s1 = PRW'(ticks_s1) * PRW'(um_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			fire_s1  <= fire_c;
			ok_s1    <= ok_c;
			warm_s1  <= warm_c;
			ptr_s1   <= ptr_q;
			ticks_s1 <= ticks_c;
			fire_s2  <= fire_s1;
			ok_s2    <= ok_s1;
			warm_s2  <= warm_s1;
			ptr_s2   <= ptr_s1;
			raw_s2   <= DIST_W'(prod_s1);
		end
	end

	// replace the oldest reading and keep the running sum in step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (adv && v_s2 && ok_s2) begin
			hist_q[ptr_s2] <= raw_s2;
			sum_q          <= sum_q - SUMW'(hist_q[ptr_s2]) + SUMW'(raw_s2);
		end
	end

	assign div_side_in.fire  = fire_s2;
	assign div_side_in.ready = ok_s2;
	assign div_side_in.warm  = warm_s2;
	assign div_side_in.raw   = ok_s2 ? raw_s2 : '0;

	uer_div #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (v_s2),
		.in_sum  (sum_q),
		.in_side (div_side_in),
		.out_v   (div_v),
		.out_quot(div_quot),
		.out_side(div_side)
	);

	always_comb begin
		res_c.fire  = div_side.fire;
		res_c.ready = div_side.ready;
		res_c.raw   = div_side.raw;
		if (!div_side.ready) begin
			res_c.filt = '0;
		end else if (div_side.warm) begin
			res_c.filt = div_side.raw;
		end else begin
			res_c.filt = div_quot;
		end
	end

	assign out_take = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_take) begin
				skid_v_q <= 1'b0;
			end
		end else if (div_v) begin
			if (!out_v_q || out_take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (div_v) begin
			if (!out_v_q || out_take) begin
				out_q <= res_c;
			end else begin
				skid_q <= res_c;
			end
		end
	end

	assign out_valid            = out_v_q;
	assign trigger_fire         = out_q.fire;
	assign reading_ready        = out_q.ready;
	assign raw_distance_um      = out_q.raw;
	assign filtered_distance_um = out_q.filt;

endmodule

// File: tb/ultrasonic_echo_ranger_tb.sv
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_tb import uer_pkg::*; ();

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int OVF_MAX = (1 << OVERFLOW_BITS_DEF) - 1;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 325;

	typedef struct packed {
		logic [1:0]        kind;
		logic              ovf;
		logic              cap;
		logic [CAPT_W-1:0] val;
	} echo_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [UM_W-1:0]   cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        kind = '0;
	logic              overflow_event = 1'b0;
	logic              capture_event = 1'b0;
	logic [CAPT_W-1:0] capture_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              trigger_fire;
	logic              reading_ready;
	logic [DIST_W-1:0] raw_distance_um;
	logic [DIST_W-1:0] filtered_distance_um;

	ultrasonic_echo_ranger dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_wdata            (cfg_wdata),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.kind                 (kind),
		.overflow_event       (overflow_event),
		.capture_event        (capture_event),
		.capture_value        (capture_value),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.trigger_fire         (trigger_fire),
		.reading_ready        (reading_ready),
		.raw_distance_um      (raw_distance_um),
		.filtered_distance_um (filtered_distance_um)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	echo_item_t pending_items[$];
	res_t       expected_readings[$];
	int         queued_total = 0;
	int         err_cnt = 0;
	int         stall_pct = 0;
	int         gap_max = 0;
	int         hold_req = 0;
	int         hold_seen = 0;
	int         hold_left = 0;
	int         gap_left = 0;
	int         burst_left = 0;
	int         quiet = 0;
	bit         item_taken = 1'b0;

	logic [UM_W-1:0]   scale_cfg = UM_RESET;
	logic              done_q = 1'b0;
	logic              echo_q = 1'b0;
	logic              armed_q = 1'b0;
	int                ovf_cnt = 0;
	logic [CAPT_W-1:0] latch_q = '0;
	logic [DIST_W-1:0] hist_mem [HISTORY_DEPTH_DEF] = '{default: '0};
	int                hist_ptr = 0;
	int                warm_cnt = 0;

	function automatic res_t next_reading(input echo_item_t it);
		res_t        r;
		logic [63:0] ticks;
		logic [63:0] dist_um;
		logic [63:0] sum;
		r = '0;
		case (it.kind)
			KIND_TIMER: begin
				if (!done_q) begin
					if (it.ovf && echo_q) begin
						if (ovf_cnt >= OVF_MAX) begin
							done_q = 1'b1;
							latch_q = CAPT_WRAPPED;
						end else begin
							ovf_cnt++;
						end
					end
					if (it.cap) begin
						if (echo_q) begin
							done_q = 1'b1;
							latch_q = it.val;
						end else begin
							ovf_cnt = 0;
							latch_q = '0;
							echo_q = 1'b1;
						end
					end
				end
			end
			KIND_TRIG: begin
				if (!armed_q && !echo_q && !done_q) begin
					armed_q = 1'b1;
					r.fire = 1'b1;
				end
			end
			KIND_READ: begin
				if (done_q) begin
					ticks = 64'(ovf_cnt) * 64'hffff + 64'(latch_q);
					dist_um = ticks * 64'(scale_cfg);
					done_q = 1'b0;
					echo_q = 1'b0;
					ovf_cnt = 0;
					armed_q = 1'b0;
					if (dist_um != 0) begin
						r.raw = dist_um[DIST_W-1:0];
						r.ready = 1'b1;
						if (warm_cnt < HISTORY_DEPTH_DEF) begin
							warm_cnt++;
							r.filt = r.raw;
						end else begin
							sum = '0;
							for (int i = 0; i < HISTORY_DEPTH_DEF; i++)
								sum += 64'(hist_mem[i]);
							sum = sum / HISTORY_DEPTH_DEF;
							r.filt = sum[DIST_W-1:0];
						end
						hist_mem[hist_ptr] = r.raw;
						hist_ptr = (hist_ptr + 1) % HISTORY_DEPTH_DEF;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic flag_error(input string msg);
		if (err_cnt < 100)
			$display("ERROR at %0t ns: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic push_item(input logic [1:0] k, input logic o, input logic c,
			input logic [CAPT_W-1:0] v);
		echo_item_t it;
		it.kind = k;
		it.ovf = o;
		it.cap = c;
		it.val = v;
		pending_items.push_back(it);
		queued_total++;
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_scale(input logic [UM_W-1:0] v);
		wait_drained();
		repeat (12) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		scale_cfg = v;
	endtask

	task automatic fill_random(input int count);
		int target;
		int n;
		target = queued_total + count;
		while (queued_total < target) begin
			if ($urandom_range(0, 4) == 0) begin
				push_item(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
					16'($urandom));
			end else begin
				if ($urandom_range(0, 3) != 0)
					push_item(KIND_TRIG, 1'($urandom), 1'($urandom), 16'($urandom));
				push_item(KIND_TIMER, 1'($urandom), 1'b1, 16'($urandom));
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
				repeat (n) begin
					if ($urandom_range(0, 9) == 0)
						push_item(KIND_TRIG, 1'($urandom), 1'($urandom), 16'($urandom));
					push_item(KIND_TIMER, 1'b1, 1'b0, 16'($urandom));
				end
				push_item(KIND_TIMER, 1'($urandom), 1'b1,
					($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom));
				if ($urandom_range(0, 5) == 0)
					push_item(KIND_TIMER, 1'($urandom), 1'($urandom), 16'($urandom));
				if ($urandom_range(0, 9) != 0)
					push_item(KIND_READ, 1'($urandom), 1'($urandom), 16'($urandom));
			end
		end
	endtask

	always @(posedge clk) begin : accept_in
		echo_item_t cur;
		if (arst_n && in_valid && !in_stall) begin
			cur.kind = kind;
			cur.ovf = overflow_event;
			cur.cap = capture_event;
			cur.val = capture_value;
			expected_readings.push_back(next_reading(cur));
			pending_items.pop_front();
			item_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !item_taken) begin
				// hold
			end else if (gap_left > 0 || pending_items.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				kind <= pending_items[0].kind;
				overflow_event <= pending_items[0].ovf;
				capture_event <= pending_items[0].cap;
				capture_value <= pending_items[0].val;
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left = $urandom_range(0, gap_max);
				end
			end
			item_taken = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_out
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				flag_error("result item with nothing expected");
			end else begin
				want = expected_readings.pop_front();
				if (trigger_fire !== want.fire)
					flag_error($sformatf("trigger_fire %0d, expected %0d",
						trigger_fire, want.fire));
				if (reading_ready !== want.ready)
					flag_error($sformatf("reading_ready %0d, expected %0d",
						reading_ready, want.ready));
				if (raw_distance_um !== want.raw)
					flag_error($sformatf("raw_distance_um %0d, expected %0d",
						raw_distance_um, want.raw));
				if (filtered_distance_um !== want.filt)
					flag_error($sformatf("filtered_distance_um %0d, expected %0d",
						filtered_distance_um, want.filt));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
			$display("** ultrasonic_echo_ranger: FAILED **");
			$finish;
		end
	end

	initial begin
		int scales [6];
		int stalls [6];
		int gaps [6];
		scales = '{1, 1023, 512, $urandom_range(1, 1023), 170, $urandom_range(1, 1023)};
		stalls = '{0, 30, 70, 10, 50, 20};
		gaps = '{0, 3, 1, 8, 2, 4};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		stall_pct = 25;
		gap_max = 2;
		push_item(KIND_READ, 1'b1, 1'b1, 16'hffff);
		push_item(KIND_NONE, 1'b1, 1'b1, 16'hffff);
		push_item(KIND_TIMER, 1'b1, 1'b0, 16'h0000);
		push_item(KIND_TRIG, 1'b0, 1'b0, 16'h0000);
		push_item(KIND_TRIG, 1'b1, 1'b1, 16'hffff);
		push_item(KIND_TIMER, 1'b1, 1'b1, 16'hffff);
		push_item(KIND_TRIG, 1'b0, 1'b0, 16'h0000);
		push_item(KIND_TIMER, 1'b1, 1'b0, 16'h5555);
		push_item(KIND_TIMER, 1'b1, 1'b1, 16'h0000);
		push_item(KIND_TIMER, 1'b1, 1'b1, 16'h1234);
		push_item(KIND_TRIG, 1'b0, 1'b0, 16'h0000);
		push_item(KIND_READ, 1'b0, 1'b0, 16'h0000);
		push_item(KIND_TIMER, 1'b0, 1'b1, 16'h0005);
		push_item(KIND_TIMER, 1'b0, 1'b1, 16'h0000);
		push_item(KIND_READ, 1'b0, 1'b0, 16'h0000);
		push_item(KIND_READ, 1'b0, 1'b0, 16'h0000);
		push_item(KIND_TIMER, 1'b0, 1'b1, 16'h0000);
		push_item(KIND_TIMER, 1'b0, 1'b1, 16'hffff);
		push_item(KIND_READ, 1'b0, 1'b0, 16'h0000);
		push_item(KIND_TIMER, 1'b0, 1'b1, 16'h0000);
		push_item(KIND_TIMER, 1'b0, 1'b1, 16'h0001);
		push_item(KIND_READ, 1'b0, 1'b0, 16'h0000);
		push_item(KIND_TIMER, 1'b0, 1'b1, 16'h0000);
		push_item(KIND_TIMER, 1'b0, 1'b1, 16'h8000);
		push_item(KIND_READ, 1'b0, 1'b0, 16'h0000);
		push_item(KIND_TRIG, 1'b0, 1'b0, 16'h0000);

		for (int p = 0; p < 6; p++) begin
			set_scale(scales[p][UM_W-1:0]);
			stall_pct = stalls[p];
			gap_max = gaps[p];
			fill_random(PHASE_ITEMS);
			if (p == 1 || p == 4)
				hold_req++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (err_cnt == 0) begin
			$display("** ultrasonic_echo_ranger: PASSED **");
		end else begin
			$display("** ultrasonic_echo_ranger: FAILED **");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/uer_pkg.sv
rtl/uer_div.sv
rtl/ultrasonic_echo_ranger.sv
tb/ultrasonic_echo_ranger_tb.sv
